// ----- sv/bmpd_pkg.sv -----
// Shared types and constants for the button multi-press detector.
`timescale 1ns / 1ps

package bmpd_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [TimeW-1:0]   time_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [CodeW-1:0] {
    EvtNone   = 2'd0,
    EvtSingle = 2'd1,
    EvtDouble = 2'd2,
    EvtTriple = 2'd3
  } evt_e;

  localparam cfg_idx_t CfgShortPress  = 3'd0;
  localparam cfg_idx_t CfgComboMin    = 3'd1;
  localparam cfg_idx_t CfgComboMax    = 3'd2;
  localparam cfg_idx_t CfgComboReport = 3'd3;

  localparam time_t ShortPressRst  = 16'd100;
  localparam time_t ComboMinRst    = 16'd100;
  localparam time_t ComboMaxRst    = 16'd500;
  localparam time_t ComboReportRst = 16'd1500;

  localparam logic [1:0] ComboFull = 2'd3;

  typedef struct packed {
    time_t short_press;
    time_t combo_min;
    time_t combo_max;
    time_t combo_report;
  } cfg_t;

endpackage

// ----- sv/bmpd_cfg.sv -----
// Configuration register file for the button multi-press detector.
`timescale 1ns / 1ps

module bmpd_cfg
  import bmpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  cfg_idx_t cfg_index_i,
  input  time_t    cfg_data_i,
  output cfg_t     cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press  <= ShortPressRst;
      cfg_q.combo_min    <= ComboMinRst;
      cfg_q.combo_max    <= ComboMaxRst;
      cfg_q.combo_report <= ComboReportRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgShortPress:  cfg_q.short_press  <= cfg_data_i;
        CfgComboMin:    cfg_q.combo_min    <= cfg_data_i;
        CfgComboMax:    cfg_q.combo_max    <= cfg_data_i;
        CfgComboReport: cfg_q.combo_report <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/bmpd_core.sv -----
// Press tracking state and event decision for one sample word.
`timescale 1ns / 1ps

module bmpd_core
  import bmpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  time_t now_i,
  input  logic level_i,
  input  cfg_t cfg_i,
  output evt_e evt_o
);

  logic       prev_q, prev_d;
  logic       pend_q, pend_d;
  time_t      last_q, last_d;
  logic [1:0] combo_q, combo_d;
  time_t      elapsed;
  logic       fall, held, idle;

  assign elapsed = now_i - last_q;
  assign fall    = !level_i && prev_q;
  assign held    = !level_i && !prev_q;
  assign idle    = level_i && prev_q;

  always_comb begin
    prev_d  = level_i;
    pend_d  = pend_q;
    last_d  = last_q;
    combo_d = combo_q;
    evt_o   = EvtNone;
    if (fall) begin
      if (!pend_q) begin
        if ((elapsed < cfg_i.combo_max) && (elapsed > cfg_i.combo_min)) begin
          if (combo_q != ComboFull) combo_d = combo_q + 2'd1;
        end else begin
          combo_d = 2'd0;
        end
        last_d = now_i;
        pend_d = 1'b1;
      end
    end else if (held) begin
      if (pend_q && (elapsed > cfg_i.short_press)) begin
        evt_o  = EvtSingle;
        pend_d = 1'b0;
      end
    end else if (idle) begin
      if (elapsed > cfg_i.combo_report) begin
        if (combo_q == 2'd1) begin
          evt_o   = EvtDouble;
          combo_d = 2'd0;
        end else if (combo_q == 2'd2) begin
          evt_o   = EvtTriple;
          combo_d = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      pend_q  <= 1'b0;
      last_q  <= '0;
      combo_q <= '0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
      combo_q <= combo_d;
    end
  end

endmodule

// ----- sv/button_multi_press_detector.sv -----
// Top level of the button multi-press detector: input register, core, result register.
`timescale 1ns / 1ps

// Takes one button sample word (16-bit ms timestamp, active-low level) per cycle and returns
// one event word per sample: 0 none, 1 single, 2 double, 3 triple press. A sample is
// registered on entry in the input register, evaluated by the core against the press state and
// the event lands in the output register; throughput is one word per cycle
// while the output side does not stall; a stall backs up through the two registers.
// Configuration writes complete in the cycle they are presented and should be issued only while
// no sample is in flight.
module button_multi_press_detector
  import bmpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic                button_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CodeW-1:0]    event_code_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  cfg_t  cfg;
  evt_e  evt;
  logic  in_valid_q;
  time_t in_now_q;
  logic  in_level_q;
  logic  out_valid_q;
  evt_e  out_code_q;
  logic  step;
  logic  in_take;

  bmpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bmpd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .now_i   (in_now_q),
    .level_i (in_level_q),
    .cfg_i   (cfg),
    .evt_o   (evt)
  );

  assign step         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o   = in_valid_q && !step;
  assign in_take      = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign event_code_o = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_now_q   <= now_ms_i;
      in_level_q <= button_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_code_q <= evt;
  end

endmodule

// ----- sv/bmpd_checker.sv -----
// Port-level checks for the button multi-press detector and their bind.
`timescale 1ns / 1ps

module bmpd_checker
  import bmpd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CodeW-1:0] event_code_o
);

  // Held result word stays put while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_code_o))
    else $error("result word changed under stall");

  // Input side only stalls when the output side does.
  a_no_spurious_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with free output");

  // An accepted word reaches the output register when the output side is free while it waits.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result word missing after accepted sample");

  // Without an accepted sample nothing new can appear on an empty output.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_stall_o && !$past(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result word without a sample");

endmodule

bind button_multi_press_detector bmpd_checker u_bmpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_code_o (event_code_o)
);
